>>> rtl/rmd5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmd5_pkg;

   localparam int WORD_W  = 32;
   localparam int WORDS   = 16;
   localparam int ROUNDS  = 32;
   localparam int ADDR_W  = $clog2(WORDS);
   localparam int ROUND_W = $clog2(ROUNDS);
   localparam int ROT_W   = 5;

   localparam logic [WORD_W-1:0] INIT_A = 32'h67425301;
   localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
   localparam logic [WORD_W-1:0] INIT_C = 32'h98adbcfe;
   localparam logic [WORD_W-1:0] INIT_D = 32'h10432576;

   localparam logic [WORD_W-1:0] ADD_CONST [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hcc1bdeee,
      32'hf57c0faf, 32'h477c862a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b011922, 32'hfd987193, 32'ha967438e, 32'h49b40821,
      32'hfffa3942, 32'h871f6781, 32'h6d9d6122, 32'hf5de380c,
      32'ha4beea44, 32'h4bdaecf9, 32'hf6bb4b60, 32'hbecbfb70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4f30e85, 32'h04881d05,
      32'hd9d4d039, 32'he69db9e5, 32'h1f27caf8, 32'hc46ac565
   };

   localparam logic [ADDR_W-1:0] MSG_INDEX [ROUNDS] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
      4'd5, 4'd8, 4'd11, 4'd14, 4'd1, 4'd4, 4'd7, 4'd10,
      4'd13, 4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15, 4'd2
   };

   localparam logic [ROT_W-1:0] ROT_AMOUNT [ROUNDS] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
      5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23
   };

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ADDR_W-1:0]  rd_addr;
      logic               init;
      logic               step;
      logic [ROUND_W-1:0] round;
      logic               finish;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/rmd5_word_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rmd5_word_if;
   logic                       valid;
   logic                       ready;
   logic [rmd5_pkg::WORD_W-1:0] message_word;
   modport source (output valid, output message_word, input ready);
   modport sink (input valid, input message_word, output ready);
endinterface
`default_nettype wire

>>> rtl/rmd5_hash_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rmd5_hash_if;
   logic                       valid;
   logic                       ready;
   logic [rmd5_pkg::WORD_W-1:0] hash_value;
   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

>>> rtl/rmd5_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rmd5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/rmd5_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rmd5_datapath (
   input  wire logic                        clock,
   input  wire rmd5_pkg::cmd_type           cmd,
   input  wire logic [rmd5_pkg::WORD_W-1:0] message_word,
   output      logic [rmd5_pkg::WORD_W-1:0] hash_value
);
   logic [rmd5_pkg::WORD_W-1:0]   a_ff, b_ff, c_ff, d_ff;
   logic [rmd5_pkg::WORD_W-1:0]   a_in, b_in, c_in, d_in;
   logic [rmd5_pkg::WORD_W-1:0]   hash_ff, hash_in;
   logic [rmd5_pkg::WORD_W-1:0]   word;
   logic [rmd5_pkg::WORD_W-1:0]   mix;
   logic [rmd5_pkg::WORD_W-1:0]   sum;
   logic [2*rmd5_pkg::WORD_W-1:0] rot_wide;

   rmd5_ram #(
      .WIDTH (rmd5_pkg::WORD_W),
      .DEPTH (rmd5_pkg::WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (message_word),
      .rd_addr (cmd.rd_addr),
      .rd_data (word)
   );

   always_comb begin
      if (cmd.round[rmd5_pkg::ROUND_W-1]) begin
         mix = b_ff ^ c_ff ^ d_ff;
      end else begin
         mix = (b_ff & c_ff) | (~b_ff & d_ff);
      end
      sum      = a_ff + mix + word + rmd5_pkg::ADD_CONST[cmd.round];
      rot_wide = {sum, sum} << rmd5_pkg::ROT_AMOUNT[cmd.round];
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      hash_in  = hash_ff;
      if (cmd.init) begin
         a_in = rmd5_pkg::INIT_A;
         b_in = rmd5_pkg::INIT_B;
         c_in = rmd5_pkg::INIT_C;
         d_in = rmd5_pkg::INIT_D;
      end else if (cmd.step) begin
         a_in = d_ff;
         d_in = c_ff;
         c_in = b_ff;
         b_in = b_ff + rot_wide[2*rmd5_pkg::WORD_W-1:rmd5_pkg::WORD_W];
      end
      if (cmd.finish) begin
         hash_in = (rmd5_pkg::INIT_A + a_ff) ^ (rmd5_pkg::INIT_B + b_ff)
                 ^ (rmd5_pkg::INIT_C + c_ff) ^ (rmd5_pkg::INIT_D + d_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      hash_ff <= hash_in;
   end

   assign hash_value = hash_ff;
endmodule
`default_nettype wire

>>> rtl/rmd5_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rmd5_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      rmd5_pkg::cmd_type cmd
);
   localparam logic [1:0] S_LOAD  = 2'd0;
   localparam logic [1:0] S_PREP  = 2'd1;
   localparam logic [1:0] S_ROUND = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   localparam logic [rmd5_pkg::ADDR_W-1:0]  LAST_WORD  = rmd5_pkg::ADDR_W'(rmd5_pkg::WORDS - 1);
   localparam logic [rmd5_pkg::ROUND_W-1:0] LAST_ROUND = rmd5_pkg::ROUND_W'(rmd5_pkg::ROUNDS - 1);

   logic [1:0]                     state_ff, state_in;
   logic [rmd5_pkg::ADDR_W-1:0]    count_ff, count_in;
   logic [rmd5_pkg::ROUND_W-1:0]   round_ff, round_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rmd5_pkg::ROUND_W-1:0]   next_round;
   logic                           accept;
   logic                           emit;

   assign req_ready  = (state_ff == S_LOAD);
   assign accept     = req_valid && req_ready;
   assign next_round = round_ff + 1'b1;
   assign emit       = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      cmd          = '0;
      cmd.wr_addr  = count_ff;
      cmd.round    = round_ff;
      cmd.rd_addr  = rmd5_pkg::MSG_INDEX[next_round];
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               cmd.wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               if (count_ff == LAST_WORD) begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            cmd.init    = 1'b1;
            cmd.rd_addr = rmd5_pkg::MSG_INDEX[0];
            round_in    = '0;
            state_in    = S_ROUND;
         end
         S_ROUND: begin
            cmd.step = 1'b1;
            round_in = next_round;
            if (round_ff == LAST_ROUND) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (emit) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_last_word_starts_hash: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff == LAST_WORD) |=> (state_ff == S_PREP))
      else $error("hash did not start after last word");
   a_rounds_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP) |=> (state_ff == S_ROUND && round_ff == '0))
      else $error("round counter not cleared at hash start");
   a_count_idle_in_hash: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> (count_ff == '0))
      else $error("word count moved during hash");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside finish");
`endif
endmodule
`default_nettype wire

>>> rtl/reduced_md5_block_fold_hash_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Each block takes 16 word beats, 1 store read, 32 rounds through one shared
// round unit and 1 fold; rsp_ch.valid rises with the fold, which waits while an
// earlier result is still unread. No words are taken during the read, rounds or fold.
// The next block's words are taken while a hash still waits on rsp_ch.
// Reset (synchronous, active high) clears the word count, the round state and
// the result valid; the word store and working words are not cleared.
module reduced_md5_block_fold_hash_core (
   input  wire logic clock,
   input  wire logic reset,
   rmd5_word_if.sink   req_ch,
   rmd5_hash_if.source rsp_ch
);
   rmd5_pkg::cmd_type cmd;

   rmd5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   rmd5_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .message_word (req_ch.message_word),
      .hash_value   (rsp_ch.hash_value)
   );
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int TOTAL_WORDS  = 1504;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_FROM    = 1500;
   localparam int CALM_TO      = 2500;
   localparam int DRAIN_CYCLES = 60;

   localparam logic [rmd5_pkg::WORD_W-1:0] SEED_A = 32'h67425301;
   localparam logic [rmd5_pkg::WORD_W-1:0] SEED_B = 32'hefcdab89;
   localparam logic [rmd5_pkg::WORD_W-1:0] SEED_C = 32'h98adbcfe;
   localparam logic [rmd5_pkg::WORD_W-1:0] SEED_D = 32'h10432576;

   localparam logic [rmd5_pkg::WORD_W-1:0] STEP_K [32] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hcc1bdeee,
      32'hf57c0faf, 32'h477c862a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b011922, 32'hfd987193, 32'ha967438e, 32'h49b40821,
      32'hfffa3942, 32'h871f6781, 32'h6d9d6122, 32'hf5de380c,
      32'ha4beea44, 32'h4bdaecf9, 32'hf6bb4b60, 32'hbecbfb70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4f30e85, 32'h04881d05,
      32'hd9d4d039, 32'he69db9e5, 32'h1f27caf8, 32'hc46ac565
   };

   logic clock;
   logic reset;

   rmd5_word_if word_ch ();
   rmd5_hash_if hash_ch ();

   reduced_md5_block_fold_hash_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (word_ch),
      .rsp_ch (hash_ch)
   );

   logic [rmd5_pkg::WORD_W-1:0] pending_words [$];
   logic [rmd5_pkg::WORD_W-1:0] expected_hashes [$];
   logic [rmd5_pkg::WORD_W-1:0] block_words [16];
   logic [3:0]                  word_slot = '0;

   int   cycle_no       = 0;
   int   idle_cycles    = 0;
   int   words_accepted = 0;
   int   fail_count     = 0;
   int   hold_left      = 0;
   logic word_taken     = 1'b0;

   always #2 clock = ~clock;

   function automatic logic [rmd5_pkg::WORD_W-1:0] fold_block();
      logic [rmd5_pkg::WORD_W-1:0] a, b, c, d, mix, sum, nb;
      int                          m, s;
      a = SEED_A;
      b = SEED_B;
      c = SEED_C;
      d = SEED_D;
      for (int r = 0; r < 32; r++) begin
         if (r < 16) begin
            mix = (b & c) | (~b & d);
            m   = r;
            case (r % 4)
               0: s = 7;
               1: s = 12;
               2: s = 17;
               default: s = 22;
            endcase
         end else begin
            mix = b ^ c ^ d;
            m   = (5 + 3 * (r - 16)) % 16;
            case (r % 4)
               0: s = 4;
               1: s = 11;
               2: s = 16;
               default: s = 23;
            endcase
         end
         sum = a + mix + block_words[m] + STEP_K[r];
         nb  = b + ((sum << s) | (sum >> (32 - s)));
         a   = d;
         d   = c;
         c   = b;
         b   = nb;
      end
      return (SEED_A + a) ^ (SEED_B + b) ^ (SEED_C + c) ^ (SEED_D + d);
   endfunction

   task automatic absorb_word(input logic [rmd5_pkg::WORD_W-1:0] w);
      block_words[word_slot] = w;
      if (word_slot == 4'd15)
         expected_hashes.push_back(fold_block());
      word_slot = word_slot + 4'd1;
   endtask

   function automatic logic [rmd5_pkg::WORD_W-1:0] random_word();
      int n;
      n = $urandom_range(31);
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         2: return 32'h1 << n;
         3: return ~(32'h1 << n);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic calm();
      return cycle_no >= CALM_FROM && cycle_no < CALM_TO;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         word_ch.valid <= 1'b0;
      end else if (!word_ch.valid || word_taken) begin
         if (pending_words.size() != 0 && (calm() || $urandom_range(99) >= 7)) begin
            word_ch.message_word <= pending_words.pop_front();
            word_ch.valid        <= 1'b1;
         end else begin
            word_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         hash_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         hash_ch.ready <= 1'b0;
      end else if (cycle_no == HOLD_AT) begin
         hold_left     <= HOLD_CYCLES;
         hash_ch.ready <= 1'b0;
      end else begin
         hash_ch.ready <= calm() || $urandom_range(99) >= 7;
      end
   end

   always @(posedge clock) begin
      logic                        word_beat, hash_beat;
      logic [rmd5_pkg::WORD_W-1:0] want;
      word_beat = !reset && word_ch.valid && word_ch.ready;
      hash_beat = !reset && hash_ch.valid && hash_ch.ready;
      cycle_no   <= cycle_no + 1;
      word_taken <= word_beat;
      if (hash_beat) begin
         if (expected_hashes.size() == 0) begin
            $display("%0t: hash %h with none expected", $time, hash_ch.hash_value);
            fail_count++;
         end else begin
            want = expected_hashes.pop_front();
            if (hash_ch.hash_value !== want) begin
               $display("%0t: hash mismatch: expected %h, actual %h",
                        $time, want, hash_ch.hash_value);
               fail_count++;
            end
         end
      end
      if (word_beat) begin
         absorb_word(word_ch.message_word);
         words_accepted++;
      end
      idle_cycles <= (word_beat || hash_beat) ? 0 : idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("reduced_md5_block_fold_hash_core regression: fail");
         $finish;
      end
   end

   initial begin
      logic [rmd5_pkg::WORD_W-1:0] edge_block [16];
      clock                = 1'b0;
      reset                = 1'b1;
      word_ch.valid        = 1'b0;
      word_ch.message_word = '0;
      hash_ch.ready        = 1'b0;

      edge_block = '{
         32'h00000000, 32'hffffffff, 32'h00000001, 32'h80000000,
         32'h7fffffff, 32'hfffffffe, 32'h55555555, 32'haaaaaaaa,
         32'h000000ff, 32'hff000000, 32'h01234567, 32'h89abcdef,
         32'h0000ffff, 32'hffff0000, 32'h00000000, 32'hffffffff
      };
      foreach (edge_block[i])
         pending_words.push_back(edge_block[i]);
      repeat (9)
         pending_words.push_back('1);
      while (pending_words.size() < TOTAL_WORDS)
         pending_words.push_back(random_word());

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (words_accepted < TOTAL_WORDS || expected_hashes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("reduced_md5_block_fold_hash_core regression: pass");
      else
         $display("reduced_md5_block_fold_hash_core regression: fail");
      $finish;
   end
endmodule

>>> sim.f
rtl/rmd5_pkg.sv
rtl/rmd5_word_if.sv
rtl/rmd5_hash_if.sv
rtl/rmd5_ram.sv
rtl/rmd5_datapath.sv
rtl/rmd5_ctrl.sv
rtl/reduced_md5_block_fold_hash_core.sv
tb/tb.sv
